FILE: sv/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg: shared types and constants of the great-circle radius filter
// Formats of angles, CORDIC vectors and the per-transaction metadata that
// travels with them through the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gcr_pkg;

    // Field widths.
    localparam int ID_W  = 32;
    localparam int LAT_W = 24;
    localparam int LON_W = 25;
    localparam int THR_W = 32;
    localparam int CFG_IDX_W = 2;

    // Angles are degrees scaled by 2^ANGLE_FRAC_BITS.
    localparam int ANGLE_FRAC_BITS = 16;
    // A longitude difference needs one bit more than a longitude.
    localparam int ANG_W = LON_W + 1;

    // Q2.30 values inside the CORDIC and the products, with headroom.
    localparam int VAL_W = 33;
    localparam int C_W   = VAL_W + 1;

    // Three angles per transaction: user latitude, record latitude and
    // longitude difference.
    localparam int NLANE     = 3;
    localparam int LANE_ULAT = 0;
    localparam int LANE_LAT  = 1;
    localparam int LANE_DLON = 2;

    // Folded angle magnitude: at most 90 degrees, below 2^23 at this scale.
    localparam int MAG_W   = 23;
    localparam int RAD_K_W = 25;
    localparam int PROD_W  = MAG_W + RAD_K_W;
    localparam logic [RAD_K_W-1:0] DEG2RAD_Q30 = 25'd18740330;

    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef ang_t [NLANE-1:0] gcr_angs_t;

    localparam ang_t TURN        = ang_t'(360 * (2 ** ANGLE_FRAC_BITS));
    localparam ang_t HALF        = ang_t'(180 * (2 ** ANGLE_FRAC_BITS));
    localparam ang_t NEG_HALF    = ang_t'(-180 * (2 ** ANGLE_FRAC_BITS));
    localparam ang_t QUARTER     = ang_t'(90 * (2 ** ANGLE_FRAC_BITS));
    localparam ang_t NEG_QUARTER = ang_t'(-90 * (2 ** ANGLE_FRAC_BITS));

    localparam val_t GAIN_Q30 = val_t'(652032874);
    localparam logic signed [C_W-1:0] ONE_Q30     = C_W'(64'sd1073741824);
    localparam logic signed [C_W-1:0] NEG_ONE_Q30 = C_W'(-64'sd1073741824);
    localparam logic signed [THR_W-1:0] THR_RESET = 32'sd1073708757;

    // CORDIC rotation angles atan(2^-i) in Q2.30.
    localparam int ATAN_Q30 [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0
    };

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USER_LAT = 2'd0,
        CFG_USER_LON = 2'd1,
        CFG_COS_THR  = 2'd2
    } gcr_cfg_idx_t;

    // One CORDIC vector.
    typedef struct packed {
        val_t x;
        val_t y;
        val_t z;
    } gcr_vec_t;

    typedef gcr_vec_t [NLANE-1:0] gcr_lanes_t;

    // Metadata that follows a transaction down the pipeline.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [NLANE-1:0] neg_cos;
    } gcr_meta_t;

endpackage

`default_nettype wire

FILE: sv/great_circle_radius_filter.sv
// ----------------------------------------------------------------------------
// great_circle_radius_filter: streaming great-circle radius test
// Passes a record id on when the record lies within the configured radius
// of the user position, using a CORDIC chain for all sines and cosines.
//
//   Channel   Direction  Handshake         Payload
//   s_        in         s_valid/s_ready   s_record_id, s_latitude, s_longitude
//   m_        out        m_valid/m_ready   m_match_id
//   cfg_      in         cfg_wr_en         cfg_index, cfg_wdata
//
// One transaction is accepted per clock cycle while the pipeline does not
// stall; each passes from acceptance to its result register through the input
// register, four preparation stages, one CORDIC cell per step, five product
// stages and the output register.
// Reset is synchronous and active low; it empties the pipeline and restores
// the configuration registers. The whole pipeline stalls only while a
// matching result is waiting at the output and the output is not taken;
// records that do not match or bubbles never stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_radius_filter #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration writes
    input  logic                               cfg_wr_en,
    input  logic [gcr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gcr_pkg::THR_W-1:0]          cfg_wdata,
    // Record input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [gcr_pkg::ID_W-1:0]           s_record_id,
    input  logic signed [gcr_pkg::LAT_W-1:0]   s_latitude,
    input  logic signed [gcr_pkg::LON_W-1:0]   s_longitude,
    // Match output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [gcr_pkg::ID_W-1:0]           m_match_id
);

    // Configuration registers.
    logic signed [gcr_pkg::LAT_W-1:0] ulat_reg;
    logic signed [gcr_pkg::LON_W-1:0] ulon_reg;
    logic signed [gcr_pkg::THR_W-1:0] thr_reg;

    // Pipeline control.
    logic pipe_en;
    logic in_vld_reg;
    logic [gcr_pkg::ID_W-1:0] in_id_reg;
    gcr_pkg::gcr_angs_t in_ang_reg, in_ang_next;

    logic                prep_valid;
    gcr_pkg::gcr_meta_t  prep_meta;
    gcr_pkg::gcr_lanes_t prep_lanes;

    logic [CORDIC_STEPS:0] cvld;
    gcr_pkg::gcr_meta_t    cmeta  [CORDIC_STEPS+1];
    gcr_pkg::gcr_lanes_t   clanes [CORDIC_STEPS+1];

    logic                              cmb_valid;
    logic [gcr_pkg::ID_W-1:0]          cmb_id;
    logic signed [gcr_pkg::C_W-1:0]    cmb_c;
    logic signed [gcr_pkg::C_W-1:0]    c_clamped;
    logic                              cmb_match;

    logic m_valid_reg, m_valid_next;
    logic m_load;
    logic [gcr_pkg::ID_W-1:0] m_id_reg;

    // Configuration write port; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ulat_reg <= '0;
            ulon_reg <= '0;
            thr_reg  <= gcr_pkg::THR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gcr_pkg::CFG_USER_LAT: ulat_reg <= signed'(cfg_wdata[gcr_pkg::LAT_W-1:0]);
                gcr_pkg::CFG_USER_LON: ulon_reg <= signed'(cfg_wdata[gcr_pkg::LON_W-1:0]);
                gcr_pkg::CFG_COS_THR:  thr_reg  <= signed'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // The pipeline moves unless a match sits at its end behind a held result.
    assign pipe_en = !m_valid_reg || m_ready || !(cmb_valid && cmb_match);
    assign s_ready = pipe_en;

    // Input stage: gather the three angles of one transaction.
    always_comb begin
        in_ang_next[gcr_pkg::LANE_ULAT] = gcr_pkg::ang_t'(ulat_reg);
        in_ang_next[gcr_pkg::LANE_LAT]  = gcr_pkg::ang_t'(s_latitude);
        in_ang_next[gcr_pkg::LANE_DLON] = gcr_pkg::ang_t'(s_longitude)
                                        - gcr_pkg::ang_t'(ulon_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            in_id_reg  <= s_record_id;
            in_ang_reg <= in_ang_next;
        end
    end

    gcr_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (in_vld_reg),
        .in_id     (in_id_reg),
        .in_ang    (in_ang_reg),
        .out_valid (prep_valid),
        .out_meta  (prep_meta),
        .out_lanes (prep_lanes)
    );

    // CORDIC chain: one cell per rotation step.
    assign cvld[0]   = prep_valid;
    assign cmeta[0]  = prep_meta;
    assign clanes[0] = prep_lanes;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        gcr_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (cvld[i]),
            .in_meta   (cmeta[i]),
            .in_lanes  (clanes[i]),
            .out_valid (cvld[i+1]),
            .out_meta  (cmeta[i+1]),
            .out_lanes (clanes[i+1])
        );
    end

    gcr_combine u_combine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (cvld[CORDIC_STEPS]),
        .in_meta   (cmeta[CORDIC_STEPS]),
        .in_lanes  (clanes[CORDIC_STEPS]),
        .out_valid (cmb_valid),
        .out_id    (cmb_id),
        .out_c     (cmb_c)
    );

    // Clamp the cosine to [-1, 1] and compare with the threshold.
    always_comb begin
        if (cmb_c > gcr_pkg::ONE_Q30) begin
            c_clamped = gcr_pkg::ONE_Q30;
        end else if (cmb_c < gcr_pkg::NEG_ONE_Q30) begin
            c_clamped = gcr_pkg::NEG_ONE_Q30;
        end else begin
            c_clamped = cmb_c;
        end
        cmb_match = c_clamped >= gcr_pkg::C_W'(thr_reg);
    end

    // Output register: loads whenever it is empty or its result is taken.
    assign m_valid_next = cmb_valid && cmb_match;
    assign m_load       = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_load) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_id_reg <= cmb_id;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_match_id = m_id_reg;

    // A stall only happens with a held result and a match waiting behind it.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready && cmb_valid && cmb_match))
        else $error("input stalled without a blocked match");

    // While stalled, the waiting match must not be overwritten.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> ($stable(cmb_c) && $stable(cmb_id) && cmb_valid))
        else $error("pending match lost during stall");

    // A new result only comes from a matching pipeline transaction.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmb_valid && cmb_match))
        else $error("result without a matching transaction");

    // The clamped cosine never leaves [-1, 1].
    a_clamp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmb_valid |-> (c_clamped <= gcr_pkg::ONE_Q30 && c_clamped >= gcr_pkg::NEG_ONE_Q30))
        else $error("clamped cosine out of range");

endmodule

`default_nettype wire

FILE: sv/gcr_prep.sv
// ----------------------------------------------------------------------------
// gcr_prep: angle reduction and conversion to radians
// Reduces each angle into [-180, 180) degrees, folds it into [-90, 90]
// and scales it to Q2.30 radians, ready to start a CORDIC rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_prep (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         in_id,
    input  gcr_pkg::gcr_angs_t  in_ang,
    output logic                out_valid,
    output gcr_pkg::gcr_meta_t  out_meta,
    output gcr_pkg::gcr_lanes_t out_lanes
);

    localparam int NL = gcr_pkg::NLANE;
    localparam int F  = gcr_pkg::ANGLE_FRAC_BITS;
    localparam logic [gcr_pkg::PROD_W-1:0] RND = gcr_pkg::PROD_W'(2 ** (F - 1));

    logic [3:0] vld_reg, vld_next;
    logic [31:0] id1_reg, id2_reg, id3_reg, id4_reg;

    gcr_pkg::gcr_angs_t red_reg, red_next;
    logic [gcr_pkg::MAG_W-1:0]  mag_reg [NL];
    logic [gcr_pkg::MAG_W-1:0]  mag_next [NL];
    logic [gcr_pkg::PROD_W-1:0] prod_reg [NL];
    logic [gcr_pkg::PROD_W-1:0] prod_next [NL];
    gcr_pkg::val_t z_reg [NL];
    gcr_pkg::val_t z_next [NL];
    logic [NL-1:0] neg2_reg, neg2_next, neg3_reg, ncos2_reg, ncos2_next, ncos3_reg;
    logic [NL-1:0] ncos4_reg;

    // Stage 1: bring the angle into [-180, 180) degrees.
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            if (in_ang[l] >= gcr_pkg::HALF) begin
                red_next[l] = in_ang[l] - gcr_pkg::TURN;
            end else if (in_ang[l] < gcr_pkg::NEG_HALF) begin
                red_next[l] = in_ang[l] + gcr_pkg::TURN;
            end else begin
                red_next[l] = in_ang[l];
            end
        end
    end

    // Stage 2: fold into [-90, 90] degrees and take the magnitude.
    always_comb begin
        gcr_pkg::ang_t m;
        gcr_pkg::ang_t mag;
        for (int l = 0; l < NL; l++) begin
            m = red_reg[l];
            ncos2_next[l] = 1'b0;
            if (m > gcr_pkg::QUARTER) begin
                mag = gcr_pkg::HALF - m;
                ncos2_next[l] = 1'b1;
            end else if (m < gcr_pkg::NEG_QUARTER) begin
                mag = gcr_pkg::HALF + m;
                ncos2_next[l] = 1'b1;
            end else if (m < 0) begin
                mag = -m;
            end else begin
                mag = m;
            end
            neg2_next[l] = m[gcr_pkg::ANG_W-1];
            mag_next[l]  = mag[gcr_pkg::MAG_W-1:0];
        end
    end

    // Stage 3: multiply by pi/180 in Q2.30.
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            prod_next[l] = {{gcr_pkg::RAD_K_W{1'b0}}, mag_reg[l]}
                         * {{gcr_pkg::MAG_W{1'b0}}, gcr_pkg::DEG2RAD_Q30};
        end
    end

    // Stage 4: round half up, drop the fraction and restore the sign.
    always_comb begin
        logic [gcr_pkg::PROD_W-1:0] rnd;
        logic [gcr_pkg::PROD_W-1:0] rsh;
        gcr_pkg::val_t r;
        for (int l = 0; l < NL; l++) begin
            rnd = prod_reg[l] + RND;
            rsh = rnd >> F;
            r   = signed'(rsh[gcr_pkg::VAL_W-1:0]);
            z_next[l] = neg3_reg[l] ? -r : r;
        end
    end

    assign vld_next = {vld_reg[2:0], in_valid};

    // Valid chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg   <= red_next;
            id1_reg   <= in_id;
            mag_reg   <= mag_next;
            neg2_reg  <= neg2_next;
            ncos2_reg <= ncos2_next;
            id2_reg   <= id1_reg;
            prod_reg  <= prod_next;
            neg3_reg  <= neg2_reg;
            ncos3_reg <= ncos2_reg;
            id3_reg   <= id2_reg;
            z_reg     <= z_next;
            ncos4_reg <= ncos3_reg;
            id4_reg   <= id3_reg;
        end
    end

    // Every rotation starts on the x axis, pre-scaled by the inverse CORDIC gain.
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            out_lanes[l].x = gcr_pkg::GAIN_Q30;
            out_lanes[l].y = '0;
            out_lanes[l].z = z_reg[l];
        end
    end

    assign out_valid        = vld_reg[3];
    assign out_meta.id      = id4_reg;
    assign out_meta.neg_cos = ncos4_reg;

endmodule

`default_nettype wire

FILE: sv/gcr_cordic_cell.sv
// ----------------------------------------------------------------------------
// gcr_cordic_cell: one rotation step of the CORDIC chain
// Rotates all three lanes by atan(2^-STEP) toward z = 0 and hands the
// vectors and the metadata on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  gcr_pkg::gcr_meta_t  in_meta,
    input  gcr_pkg::gcr_lanes_t in_lanes,
    output logic                out_valid,
    output gcr_pkg::gcr_meta_t  out_meta,
    output gcr_pkg::gcr_lanes_t out_lanes
);

    localparam gcr_pkg::val_t ATAN = gcr_pkg::val_t'(gcr_pkg::ATAN_Q30[STEP]);

    logic                valid_reg;
    gcr_pkg::gcr_meta_t  meta_reg;
    gcr_pkg::gcr_lanes_t lanes_reg, lanes_next;

    // Micro-rotation; the direction follows the sign of the residual angle.
    always_comb begin
        gcr_pkg::val_t xs;
        gcr_pkg::val_t ys;
        for (int l = 0; l < gcr_pkg::NLANE; l++) begin
            xs = in_lanes[l].x >>> STEP;
            ys = in_lanes[l].y >>> STEP;
            if (!in_lanes[l].z[gcr_pkg::VAL_W-1]) begin
                lanes_next[l].x = in_lanes[l].x - ys;
                lanes_next[l].y = in_lanes[l].y + xs;
                lanes_next[l].z = in_lanes[l].z - ATAN;
            end else begin
                lanes_next[l].x = in_lanes[l].x + ys;
                lanes_next[l].y = in_lanes[l].y - xs;
                lanes_next[l].z = in_lanes[l].z + ATAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_reg  <= in_meta;
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_meta  = meta_reg;
    assign out_lanes = lanes_reg;

endmodule

`default_nettype wire

FILE: sv/gcr_combine.sv
// ----------------------------------------------------------------------------
// gcr_combine: spherical law of cosines
// Applies the cosine signs from folding, then forms
// sin(ulat)sin(lat) + (cos(ulat)cos(lat))cos(dlon) with Q2.30 rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_combine (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  gcr_pkg::gcr_meta_t      in_meta,
    input  gcr_pkg::gcr_lanes_t     in_lanes,
    output logic                    out_valid,
    output logic [31:0]             out_id,
    output logic signed [gcr_pkg::C_W-1:0] out_c
);

    localparam int VW = gcr_pkg::VAL_W;
    localparam int PW = 2 * VW;

    // Q2.30 product rounding: floor((p + 2^29) / 2^30).
    function automatic gcr_pkg::val_t round_q30(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + PW'(64'sd536870912);
        return signed'(t[30 +: VW]);
    endfunction

    logic [4:0] vld_reg, vld_next;
    logic [31:0] id1_reg, id2_reg, id3_reg, id4_reg, id5_reg;

    gcr_pkg::val_t su_reg, sl_reg, cu_reg, cl_reg, cd1_reg;
    gcr_pkg::val_t cu_next, cl_next, cd_next;
    logic signed [PW-1:0] ps_reg, pc_reg, p3_reg;
    gcr_pkg::val_t cd2_reg, cd3_reg, r1_reg, r1b_reg, r2_reg;
    logic signed [gcr_pkg::C_W-1:0] c_reg, c_next;

    // Stage 1: cosines of folded angles change sign.
    always_comb begin
        cu_next = in_meta.neg_cos[gcr_pkg::LANE_ULAT]
                ? -in_lanes[gcr_pkg::LANE_ULAT].x : in_lanes[gcr_pkg::LANE_ULAT].x;
        cl_next = in_meta.neg_cos[gcr_pkg::LANE_LAT]
                ? -in_lanes[gcr_pkg::LANE_LAT].x : in_lanes[gcr_pkg::LANE_LAT].x;
        cd_next = in_meta.neg_cos[gcr_pkg::LANE_DLON]
                ? -in_lanes[gcr_pkg::LANE_DLON].x : in_lanes[gcr_pkg::LANE_DLON].x;
    end

    // Stage 5: round the last product and add the sine term.
    assign c_next = gcr_pkg::C_W'(r1b_reg) + gcr_pkg::C_W'(round_q30(p3_reg));

    assign vld_next = {vld_reg[3:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // Stages 1 to 5: sign fix, two products, rounding, third product, sum.
    always_ff @(posedge aclk) begin
        if (en) begin
            su_reg  <= in_lanes[gcr_pkg::LANE_ULAT].y;
            sl_reg  <= in_lanes[gcr_pkg::LANE_LAT].y;
            cu_reg  <= cu_next;
            cl_reg  <= cl_next;
            cd1_reg <= cd_next;
            id1_reg <= in_meta.id;

            ps_reg  <= PW'(su_reg) * PW'(sl_reg);
            pc_reg  <= PW'(cu_reg) * PW'(cl_reg);
            cd2_reg <= cd1_reg;
            id2_reg <= id1_reg;

            r1_reg  <= round_q30(ps_reg);
            r2_reg  <= round_q30(pc_reg);
            cd3_reg <= cd2_reg;
            id3_reg <= id2_reg;

            p3_reg  <= PW'(r2_reg) * PW'(cd3_reg);
            r1b_reg <= r1_reg;
            id4_reg <= id3_reg;

            c_reg   <= c_next;
            id5_reg <= id4_reg;
        end
    end

    assign out_valid = vld_reg[4];
    assign out_id    = id5_reg;
    assign out_c     = c_reg;

endmodule

`default_nettype wire

FILE: test/great_circle_radius_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// great_circle_radius_filter_tb: self-checking bench of the radius filter
// Streams records through the filter under several user positions and
// cosine thresholds. A bit-exact fixed-point predictor decides which record
// ids must come out, and every match is compared in order with that list.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------

// Predicts which records fall inside the radius and checks the match stream.
class radius_match_board;
    localparam longint TURN_Q16    = 23592960;
    localparam longint HALF_Q16    = 11796480;
    localparam longint QUARTER_Q16 = 5898240;
    localparam longint RAD_PER_DEG = 18740330;
    localparam longint CORDIC_X0   = 652032874;
    localparam longint ONE_Q30     = 1073741824;
    localparam longint ROUND_Q30   = 536870912;
    localparam int     STEPS       = 24;

    longint      user_lat;
    longint      user_lon;
    longint      threshold;
    longint      atan_q30 [32];
    logic [31:0] expected_ids [$];
    int          errors;
    int          records;
    int          match_count;

    function new();
        atan_q30 = '{
            843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
            65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
            16, 8, 4, 2, 1, 0
        };
        user_lat    = 0;
        user_lon    = 0;
        threshold   = 1073708757;
        errors      = 0;
        records     = 0;
        match_count = 0;
    endfunction

    // Registers sign-extend from their own width; a spare index changes nothing.
    function void write_reg(logic [gcr_pkg::CFG_IDX_W-1:0] idx,
                            logic [gcr_pkg::THR_W-1:0] data);
        case (idx)
            gcr_pkg::CFG_USER_LAT: user_lat  = longint'($signed(data[gcr_pkg::LAT_W-1:0]));
            gcr_pkg::CFG_USER_LON: user_lon  = longint'($signed(data[gcr_pkg::LON_W-1:0]));
            gcr_pkg::CFG_COS_THR:  threshold = longint'($signed(data));
            default: ;
        endcase
    endfunction

    // Reduces an angle to [-90, 90] degrees and runs the rotation CORDIC.
    function void sin_cos(longint ang, output longint sin_q30, output longint cos_q30);
        longint m;
        longint mag;
        longint rad;
        longint x;
        longint y;
        longint z;
        longint nx;
        bit     flip;
        flip = 0;
        m = ang % TURN_Q16;
        if (m < 0) m += TURN_Q16;
        if (m >= HALF_Q16) m -= TURN_Q16;
        if (m > QUARTER_Q16) begin
            m = HALF_Q16 - m;
            flip = 1;
        end else if (m < -QUARTER_Q16) begin
            m = -HALF_Q16 - m;
            flip = 1;
        end
        mag = (m < 0) ? -m : m;
        rad = (mag * RAD_PER_DEG + 32768) >>> 16;
        if (m < 0) rad = -rad;
        x = CORDIC_X0;
        y = 0;
        z = rad;
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_q30[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_q30[i];
            end
            x = nx;
        end
        sin_q30 = y;
        cos_q30 = flip ? -x : x;
    endfunction

    function longint mul_q30(longint a, longint b);
        return (a * b + ROUND_Q30) >>> 30;
    endfunction

    // Computes the central-angle cosine of one record and notes a match.
    function void note_record(logic [gcr_pkg::ID_W-1:0] id,
                              logic signed [gcr_pkg::LAT_W-1:0] lat,
                              logic signed [gcr_pkg::LON_W-1:0] lon);
        longint su;
        longint cu;
        longint sl;
        longint cl;
        longint sd;
        longint cd;
        longint cosine;
        sin_cos(user_lat, su, cu);
        sin_cos(longint'(lat), sl, cl);
        sin_cos(longint'(lon) - user_lon, sd, cd);
        cosine = mul_q30(su, sl) + mul_q30(mul_q30(cu, cl), cd);
        if (cosine > ONE_Q30) cosine = ONE_Q30;
        if (cosine < -ONE_Q30) cosine = -ONE_Q30;
        records++;
        if (cosine >= threshold) expected_ids.push_back(id);
    endfunction

    // Compares one match transaction with the oldest pending id.
    function void check_match(logic [gcr_pkg::ID_W-1:0] id);
        logic [gcr_pkg::ID_W-1:0] want;
        if (expected_ids.size() == 0) begin
            errors++;
            $error("match_id: no match pending, actual %h", id);
        end else begin
            want = expected_ids.pop_front();
            match_count++;
            if (id !== want) begin
                errors++;
                $error("match_id: expected %h, actual %h", want, id);
            end
        end
    endfunction
endclass

module great_circle_radius_filter_tb;

    localparam int CORDIC_STEPS  = 24;
    localparam int PIPE_LATENCY  = CORDIC_STEPS + 11;
    localparam int TAIL_CYCLES   = 2 * PIPE_LATENCY;
    localparam int STALL_LIMIT   = 5000;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_RECORDS = 190;
    localparam int NEAR_SPAN     = 45000;
    localparam int DEG           = 65536;
    localparam int LAT_LIMIT     = 90 * DEG;
    localparam int LON_LIMIT     = 180 * DEG;
    localparam int TURN          = 360 * DEG;
    localparam int LON_RAW_MAX   = 16777215;
    localparam int LON_RAW_MIN   = -16777216;
    localparam logic [gcr_pkg::THR_W-1:0] THR_50KM   = 32'd1073708757;
    localparam logic [gcr_pkg::THR_W-1:0] THR_ONE    = 32'h4000_0000;
    localparam logic [gcr_pkg::THR_W-1:0] THR_NEGONE = 32'hC000_0000;
    localparam logic [gcr_pkg::THR_W-1:0] THR_TOP    = 32'h7FFF_FFFF;
    localparam logic [gcr_pkg::THR_W-1:0] THR_BOTTOM = 32'h8000_0000;
    localparam logic [gcr_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    logic                              aclk;
    logic                              aresetn     = 1'b0;
    logic                              cfg_wr_en   = 1'b0;
    logic [gcr_pkg::CFG_IDX_W-1:0]     cfg_index   = '0;
    logic [gcr_pkg::THR_W-1:0]         cfg_wdata   = '0;
    logic                              s_valid     = 1'b0;
    logic                              s_ready;
    logic [gcr_pkg::ID_W-1:0]          s_record_id = '0;
    logic signed [gcr_pkg::LAT_W-1:0]  s_latitude  = '0;
    logic signed [gcr_pkg::LON_W-1:0]  s_longitude = '0;
    logic                              m_valid;
    logic                              m_ready     = 1'b0;
    logic [gcr_pkg::ID_W-1:0]          m_match_id;

    radius_match_board sb;
    bit quiet = 1'b0;
    int stall_left = 0;
    int settings_done = 0;

    great_circle_radius_filter #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_record_id(s_record_id),
        .s_latitude (s_latitude),
        .s_longitude(s_longitude),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_match_id (m_match_id)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Idle lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int rand_span(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // Match side: check each transaction, then decide on ready for the next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_match(m_match_id);
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // Ends the run when neither channel moves for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("great_circle_radius_filter test failed");
        $finish;
    end

    // Offers one record after a random gap and holds it until the transaction.
    task automatic send_record(input logic [gcr_pkg::ID_W-1:0] id,
                               input logic signed [gcr_pkg::LAT_W-1:0] lat,
                               input logic signed [gcr_pkg::LON_W-1:0] lon);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_record_id <= id;
        s_latitude  <= lat;
        s_longitude <= lon;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_record(id, lat, lon);
    endtask

    // Mostly records near the user position, some anywhere, some raw bit patterns.
    task automatic send_random_record();
        int roll;
        int lat_v;
        int lon_v;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            lat_v = int'(sb.user_lat) + rand_span(NEAR_SPAN);
            lon_v = int'(sb.user_lon) + rand_span(NEAR_SPAN);
            // The same meridian seen one full turn away.
            if ($urandom_range(0, 3) == 0) begin
                if (lon_v + TURN <= LON_RAW_MAX) lon_v += TURN;
                else if (lon_v - TURN >= LON_RAW_MIN) lon_v -= TURN;
            end
        end else if (roll < 85) begin
            lat_v = rand_span(LAT_LIMIT);
            lon_v = rand_span(LON_LIMIT);
        end else begin
            lat_v = $urandom();
            lon_v = $urandom();
        end
        send_record($urandom(), gcr_pkg::LAT_W'(lat_v), gcr_pkg::LON_W'(lon_v));
    endtask

    // Waits for every pending match, then lets the pipeline empty.
    task automatic drain_matches(input int tail);
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.expected_ids.size() != 0);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [gcr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gcr_pkg::THR_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    // Loads a user position and threshold; the spare index goes last so that
    // a wrong decode of it would corrupt a live register.
    task automatic write_filter(input int lat_v, input int lon_v,
                                input logic [gcr_pkg::THR_W-1:0] thr);
        cfg_write(gcr_pkg::CFG_USER_LAT, {8'($urandom()), gcr_pkg::LAT_W'(lat_v)});
        cfg_write(gcr_pkg::CFG_USER_LON, {7'($urandom()), gcr_pkg::LON_W'(lon_v)});
        cfg_write(gcr_pkg::CFG_COS_THR, thr);
        cfg_write(CFG_SPARE_IDX, $urandom());
        cfg_wr_en <= 1'b0;
        settings_done++;
    endtask

    initial begin
        int lat_v;
        int lon_v;
        logic [gcr_pkg::THR_W-1:0] thr;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: user at the origin, 50 km radius.
        send_record(32'h0000_0000, '0, '0);
        send_record(32'hFFFF_FFFF, '0, '0);
        send_record(32'hA5A5_A5A5, 24'sh7F_FFFF, 25'sh0FF_FFFF);
        send_record(32'h5A5A_5A5A, 24'sh80_0000, 25'sh100_0000);
        send_record(32'd1, gcr_pkg::LAT_W'(LAT_LIMIT), '0);
        send_record(32'd2, gcr_pkg::LAT_W'(-LAT_LIMIT), '0);
        send_record(32'd3, '0, gcr_pkg::LON_W'(LON_LIMIT));
        send_record(32'd4, '0, gcr_pkg::LON_W'(-LON_LIMIT));
        // Just inside and just outside the radius on each axis.
        send_record(32'd5, '0, gcr_pkg::LON_W'(29000));
        send_record(32'd6, '0, gcr_pkg::LON_W'(30000));
        send_record(32'd7, gcr_pkg::LAT_W'(29471), '0);
        send_record(32'd8, gcr_pkg::LAT_W'(-29472), '0);
        send_record(32'd9, gcr_pkg::LAT_W'(20833), gcr_pkg::LON_W'(20833));
        // Angles past the pole and past the date line wrap as plain angles.
        send_record(32'd10, gcr_pkg::LAT_W'(100 * DEG), '0);
        send_record(32'd11, gcr_pkg::LAT_W'(-100 * DEG), '0);
        send_record(32'd12, '0, gcr_pkg::LON_W'(200 * DEG));
        send_record(32'd13, '0, gcr_pkg::LON_W'(-200 * DEG));
        send_record(32'd14, gcr_pkg::LAT_W'(1), gcr_pkg::LON_W'(-1));
        send_record(32'd15, gcr_pkg::LAT_W'(-1), gcr_pkg::LON_W'(1));

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_matches(TAIL_CYCLES);
            lat_v = rand_span(LAT_LIMIT);
            lon_v = rand_span(LON_LIMIT);
            thr   = THR_50KM;
            case (p)
                1: begin
                    lat_v = LAT_LIMIT;
                    lon_v = -LON_LIMIT;
                end
                2: begin
                    lat_v = -LAT_LIMIT;
                    lon_v = LON_LIMIT;
                    thr   = THR_ONE - $urandom_range(0, 1 << 22);
                end
                3: thr = THR_NEGONE;
                4: thr = THR_ONE;
                5: begin
                    // Raw register patterns, positions beyond the usual range.
                    lat_v = $urandom();
                    lon_v = $urandom();
                    thr   = THR_TOP;
                end
                6: thr = THR_BOTTOM;
                7: begin
                    lat_v = 0;
                    lon_v = 0;
                    thr   = '0;
                end
                8: thr = $urandom();
                default: ;
            endcase
            write_filter(lat_v, lon_v, thr);
            quiet = (p == 4 || p == 9);
            for (int i = 0; i < PHASE_RECORDS; i++) begin
                send_random_record();
                // Hold the sender once until the match stream has caught up.
                if (p == 1 && i == PHASE_RECORDS / 2) drain_matches(0);
            end
        end
        drain_matches(TAIL_CYCLES);

        $display("Covered %0d records and %0d matches under %0d filter settings,",
                 sb.records, sb.match_count, settings_done + 1);
        $display("including pole, date-line and threshold extremes with random stalls.");
        if (sb.errors == 0) begin
            $display("great_circle_radius_filter test passed");
        end else begin
            $display("great_circle_radius_filter test failed");
        end
        $finish;
    end

endmodule
